// ===== rtl/jps_pkg.sv =====
// Shared types and constants of the job priority sorter.
package jps_pkg;

    localparam int MAX_JOBS = 64;
    localparam int MixW     = 10;
    localparam int PriW     = 7;
    localparam int CountW   = $clog2(MAX_JOBS + 1);

    typedef logic [MixW-1:0]   t_mix;
    typedef logic [PriW-1:0]   t_pri;
    typedef logic [CountW-1:0] t_count;

    typedef struct packed {
        t_mix mix_number;
        t_pri priority_req;
        logic in_use;
        logic last_entry;
    } t_in_item;

    typedef struct packed {
        t_mix sorted_mix;
        t_pri sorted_priority;
        logic last_result;
        logic none_found;
        logic overflowed;
    } t_out_item;

    typedef struct packed {
        t_mix mix;
        t_pri pri;
    } t_job;

    typedef struct packed {
        logic valid;
        t_mix mix;
        t_pri pri;
    } t_cell;

    typedef struct packed {
        logic ins;
        logic shl;
    } t_chain_ctl;

endpackage

// ===== rtl/jps_cell.sv =====
// One cell of the sorted insertion chain.
module jps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jps_pkg::t_chain_ctl i_ctl,
    input  jps_pkg::t_job      i_new,
    input  jps_pkg::t_cell     i_prev,
    input  logic               i_prev_before,
    input  jps_pkg::t_cell     i_next,
    output jps_pkg::t_cell     o_cell,
    output logic               o_before
);
    import jps_pkg::*;

    logic r_valid;
    t_mix r_mix;
    t_pri r_pri;
    logic n_valid;
    t_mix n_mix;
    t_pri n_pri;

    // new job is served before this cell's job (empty cells always lose)
    assign o_before = !r_valid || (i_new.pri > r_pri) ||
                      ((i_new.pri == r_pri) && (i_new.mix < r_mix));

    always_comb begin
        n_valid = r_valid;
        n_mix   = r_mix;
        n_pri   = r_pri;
        if (i_ctl.shl) begin
            n_valid = i_next.valid;
            n_mix   = i_next.mix;
            n_pri   = i_next.pri;
        end else if (i_ctl.ins && o_before) begin
            if (i_prev_before) begin
                n_valid = i_prev.valid;
                n_mix   = i_prev.mix;
                n_pri   = i_prev.pri;
            end else begin
                n_valid = 1'b1;
                n_mix   = i_new.mix;
                n_pri   = i_new.pri;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mix <= n_mix;
        r_pri <= n_pri;
    end

    assign o_cell = '{valid: r_valid, mix: r_mix, pri: r_pri};

endmodule

// ===== rtl/job_priority_sorter_top.sv =====
// Top level of the job priority sorter: insertion chain, drain control, output register.
// Job-table entries are taken one per cycle while input stall is low; each kept entry
// drops into its place in a chain of MAX_JOBS cells in the cycle it is accepted. The
// item flagged last_entry starts a drain: the chain shifts toward cell 0 one cell per
// cycle, so a run with n kept jobs gives n results (one "none" result for an empty
// run), paced by the output stall. Input stall is high from the edge after the last
// entry until the final result of the run has been loaded into the output register;
// the next run may then be collected while that result waits. Jobs arriving with the
// chain full are dropped and every result of that run carries overflowed.
module job_priority_sorter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  jps_pkg::t_mix       i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  jps_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jps_pkg::t_out_item  o_out
);
    import jps_pkg::*;

    t_mix       r_first_assignable;
    t_count     r_count;
    logic       r_ovf;
    logic       r_draining;
    logic       r_out_valid;
    t_out_item  r_out;

    t_cell      w_cell [MAX_JOBS];
    logic       w_before [MAX_JOBS];
    t_chain_ctl w_ctl;
    t_job       w_new;
    logic       w_acc;
    logic       w_kept;
    logic       w_full;
    logic       w_load;
    logic       w_empty;

    assign w_acc   = i_in_valid && !r_draining;
    assign w_kept  = i_in.in_use && (i_in.mix_number >= r_first_assignable);
    assign w_full  = (r_count == t_count'(MAX_JOBS));
    assign w_load  = r_draining && (!r_out_valid || !i_out_stall);
    assign w_empty = (r_count == '0);

    assign w_ctl.ins = w_acc && w_kept && !w_full;
    assign w_ctl.shl = w_load;
    assign w_new     = '{mix: i_in.mix_number, pri: i_in.priority_req};

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_chain
        t_cell w_prev;
        t_cell w_next;
        logic  w_prev_before;
        if (g == 0) begin : g_head
            assign w_prev        = '0;
            assign w_prev_before = 1'b0;
        end else begin : g_mid
            assign w_prev        = w_cell[g-1];
            assign w_prev_before = w_before[g-1];
        end
        if (g == MAX_JOBS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end
        jps_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new         (w_new),
            .i_prev        (w_prev),
            .i_prev_before (w_prev_before),
            .i_next        (w_next),
            .o_cell        (w_cell[g]),
            .o_before      (w_before[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_assignable <= t_mix'(1);
            r_count            <= '0;
            r_ovf              <= 1'b0;
            r_draining         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_first_assignable <= i_cfg_wr_data;
            end
            if (w_acc) begin
                if (w_ctl.ins) begin
                    r_count <= r_count + t_count'(1);
                end
                if (w_kept && w_full) begin
                    r_ovf <= 1'b1;
                end
                if (i_in.last_entry) begin
                    r_draining <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_empty || (r_count == t_count'(1))) begin
                    r_draining <= 1'b0;
                    r_ovf      <= 1'b0;
                end
                if (!w_empty) begin
                    r_count <= r_count - t_count'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.sorted_mix      <= w_empty ? '0 : w_cell[0].mix;
            r_out.sorted_priority <= w_empty ? '0 : w_cell[0].pri;
            r_out.last_result     <= w_empty || (r_count == t_count'(1));
            r_out.none_found      <= w_empty;
            r_out.overflowed      <= r_ovf;
        end
    end

    assign o_in_stall  = r_draining;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/jps_checker.sv =====
// Port-level checks of the job priority sorter, bound to the top level.
module jps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input jps_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input jps_pkg::t_out_item o_out
);
    import jps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output item changed");

    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.none_found |->
            o_out.last_result && !o_out.overflowed &&
            (o_out.sorted_mix == '0) && (o_out.sorted_priority == '0))
        else $error("malformed empty-run result");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.last_entry |=> o_in_stall)
        else $error("input not stalled after last entry");

    a_drain_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_result |-> o_in_stall)
        else $error("input open while run still draining");

endmodule

bind job_priority_sorter_top jps_checker u_jps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
